[sv/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// pfa_pkg
// shared constants, codes and controller/datapath interface types for the
// page frame allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

    // built frame count default and frame size
    localparam int NUM_FRAMES_DEF = 64;
    localparam int FRAME_BYTES    = 256;
    localparam int FB_SHIFT       = $clog2(FRAME_BYTES);

    // field widths
    localparam int REQ_W    = 16;
    localparam int CFG_W    = 7;
    localparam int COUNT_W  = 7;
    localparam int MAP_W    = 64;
    localparam int FRAG_W   = 8;
    localparam int STATUS_W = 2;
    localparam int MEM_W    = 17;

    // stream word widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 80;

    localparam logic [CFG_W-1:0] TOTAL_FRAMES_RESET = 7'd64;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_FRAME = 2'd1,
        STATUS_BAD_REQ  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic check;
        logic scan_step;
        logic commit;
        logic load_out;
    } pfa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic req_ok;
        logic scan_done;
    } pfa_sts_t;

endpackage

[sv/pfa_ctrl.sv]
// ----------------------------------------------------------------------------
// pfa_ctrl
// sequencer for one request: accept, check, frame scan, result hand-off
// ----------------------------------------------------------------------------
module pfa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  pfa_pkg::pfa_sts_t sts,
    output pfa_pkg::pfa_cmd_t cmd
);

    pfa_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pfa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            pfa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = pfa_pkg::ST_CHECK;
                end
            end
            pfa_pkg::ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = sts.req_ok ? pfa_pkg::ST_SCAN : pfa_pkg::ST_FINISH;
            end
            pfa_pkg::ST_SCAN: begin
                if (sts.scan_done) begin
                    cmd.commit = 1'b1;
                    state_next = pfa_pkg::ST_FINISH;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            pfa_pkg::ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = pfa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfa_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    // a result is never loaded over one that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("pfa_ctrl: result overwritten before it was taken");

    // an accepted word always goes to the check step next
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == pfa_pkg::ST_CHECK))
        else $error("pfa_ctrl: accepted word not checked");

    // the scan never steps once it has finished
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> !sts.scan_done)
        else $error("pfa_ctrl: scan stepped past its end");
`endif

endmodule

[sv/pfa_datapath.sv]
// ----------------------------------------------------------------------------
// pfa_datapath
// busy bitmap, frame count registers, request check, frame scan and the
// result register
// ----------------------------------------------------------------------------
module pfa_datapath #(
    parameter int NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [pfa_pkg::REQ_W-1:0]       req_in,
    input  logic                            cfg_we,
    input  logic [pfa_pkg::CFG_W-1:0]       cfg_data,
    input  pfa_pkg::pfa_cmd_t               cmd,
    output pfa_pkg::pfa_sts_t               sts,
    output logic [pfa_pkg::STATUS_W-1:0]    out_status,
    output logic [pfa_pkg::MAP_W-1:0]       out_map,
    output logic [pfa_pkg::COUNT_W-1:0]     out_count,
    output logic [pfa_pkg::FRAG_W-1:0]      out_frag
);

    localparam int CNT_W = $clog2(NUM_FRAMES + 1);
    localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int FR_W  = pfa_pkg::FB_SHIFT + 1;
    localparam logic [pfa_pkg::CFG_W-1:0] NF_MAX = pfa_pkg::CFG_W'(NUM_FRAMES);
    localparam logic [pfa_pkg::MEM_W-1:0] FB_M   = pfa_pkg::MEM_W'(pfa_pkg::FRAME_BYTES);
    localparam logic [pfa_pkg::MEM_W-1:0] FB_M1  = pfa_pkg::MEM_W'(pfa_pkg::FRAME_BYTES - 1);
    localparam logic [FR_W-1:0]           FB_F   = FR_W'(pfa_pkg::FRAME_BYTES);

    // state
    logic [pfa_pkg::CFG_W-1:0]   total_frames_reg, total_frames_next;
    logic [NUM_FRAMES-1:0]       busy_reg, busy_next;
    logic [pfa_pkg::COUNT_W-1:0] frames_used_reg, frames_used_next;

    // per request
    logic [pfa_pkg::REQ_W-1:0]   req_reg, req_next;
    pfa_pkg::status_t            status_reg, status_next;
    logic [pfa_pkg::COUNT_W-1:0] need_reg, need_next;
    logic [CNT_W-1:0]            scan_idx_reg, scan_idx_next;
    logic [pfa_pkg::COUNT_W-1:0] got_reg, got_next;
    logic [NUM_FRAMES-1:0]       map_reg, map_next;

    // result
    pfa_pkg::status_t            out_status_reg, out_status_next;
    logic [pfa_pkg::MAP_W-1:0]   out_map_reg, out_map_next;
    logic [pfa_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic [pfa_pkg::FRAG_W-1:0]  out_frag_reg, out_frag_next;

    logic [pfa_pkg::CFG_W-1:0]   nf;
    logic [pfa_pkg::COUNT_W-1:0] left;
    logic [pfa_pkg::MEM_W-1:0]   mem_left, req_m, need_sum;
    logic                        big_req, small_req;
    pfa_pkg::status_t            status_calc;
    logic [pfa_pkg::COUNT_W-1:0] need_calc;
    logic                        in_range, cur_busy, scan_done;
    logic [IDX_W-1:0]            idx;
    logic [pfa_pkg::COUNT_W:0]   used_sum;
    logic [pfa_pkg::FB_SHIFT-1:0] rem;
    logic [FR_W-1:0]             frag_full;
    logic [pfa_pkg::FRAG_W-1:0]  frag_sat;

    // request check
    always_comb begin
        nf       = (total_frames_reg > NF_MAX) ? NF_MAX : total_frames_reg;
        left     = (frames_used_reg < nf) ? (nf - frames_used_reg) : '0;
        mem_left = pfa_pkg::MEM_W'(left) << pfa_pkg::FB_SHIFT;
        req_m    = pfa_pkg::MEM_W'(req_reg);
        need_sum = (req_m + FB_M1) >> pfa_pkg::FB_SHIFT;
        big_req   = (req_m >= FB_M) && (req_m <= mem_left);
        small_req = (req_reg != '0) && (req_m < FB_M);
        if (big_req) begin
            status_calc = pfa_pkg::STATUS_OK;
            need_calc   = need_sum[pfa_pkg::COUNT_W-1:0];
        end else if (small_req && (left != '0)) begin
            status_calc = pfa_pkg::STATUS_OK;
            need_calc   = pfa_pkg::COUNT_W'(1);
        end else if (small_req) begin
            status_calc = pfa_pkg::STATUS_NO_FRAME;
            need_calc   = '0;
        end else begin
            status_calc = pfa_pkg::STATUS_BAD_REQ;
            need_calc   = '0;
        end
    end

    // scan of one frame per cycle
    always_comb begin
        idx       = scan_idx_reg[IDX_W-1:0];
        in_range  = pfa_pkg::CFG_W'(scan_idx_reg) < nf;
        cur_busy  = busy_reg[idx];
        scan_done = !(in_range && (got_reg < need_reg));
        used_sum  = {1'b0, frames_used_reg} + {1'b0, got_reg};
        rem       = req_reg[pfa_pkg::FB_SHIFT-1:0];
        frag_full = (rem != '0) ? (FB_F - FR_W'(rem)) : '0;
        frag_sat  = (frag_full > FR_W'(255)) ? 8'hFF : pfa_pkg::FRAG_W'(frag_full);
    end

    assign sts.req_ok    = (status_calc == pfa_pkg::STATUS_OK);
    assign sts.scan_done = scan_done;

    always_comb begin
        total_frames_next = cfg_we ? cfg_data : total_frames_reg;
        busy_next         = busy_reg;
        frames_used_next  = frames_used_reg;
        req_next          = cmd.load_req ? req_in : req_reg;
        status_next       = status_reg;
        need_next         = need_reg;
        scan_idx_next     = scan_idx_reg;
        got_next          = got_reg;
        map_next          = map_reg;
        out_status_next   = out_status_reg;
        out_map_next      = out_map_reg;
        out_count_next    = out_count_reg;
        out_frag_next     = out_frag_reg;

        if (cmd.check) begin
            status_next   = status_calc;
            need_next     = need_calc;
            scan_idx_next = '0;
            got_next      = '0;
            map_next      = '0;
        end
        if (cmd.scan_step) begin
            if (!cur_busy) begin
                busy_next[idx] = 1'b1;
                map_next[idx]  = 1'b1;
                got_next       = got_reg + 1'b1;
            end
            scan_idx_next = scan_idx_reg + 1'b1;
        end
        if (cmd.commit) begin
            // saturate at the counter's full scale
            frames_used_next = used_sum[pfa_pkg::COUNT_W] ? '1
                             : used_sum[pfa_pkg::COUNT_W-1:0];
        end
        if (cmd.load_out) begin
            out_status_next = status_reg;
            if (status_reg == pfa_pkg::STATUS_OK) begin
                out_map_next   = pfa_pkg::MAP_W'(map_reg);
                out_count_next = got_reg;
                out_frag_next  = frag_sat;
            end else begin
                out_map_next   = '0;
                out_count_next = '0;
                out_frag_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_frames_reg <= pfa_pkg::TOTAL_FRAMES_RESET;
            busy_reg         <= '0;
            frames_used_reg  <= '0;
        end else begin
            total_frames_reg <= total_frames_next;
            busy_reg         <= busy_next;
            frames_used_reg  <= frames_used_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        status_reg     <= status_next;
        need_reg       <= need_next;
        scan_idx_reg   <= scan_idx_next;
        got_reg        <= got_next;
        map_reg        <= map_next;
        out_status_reg <= out_status_next;
        out_map_reg    <= out_map_next;
        out_count_reg  <= out_count_next;
        out_frag_reg   <= out_frag_next;
    end

    assign out_status = out_status_reg;
    assign out_map    = out_map_reg;
    assign out_count  = out_count_reg;
    assign out_frag   = out_frag_reg;

`ifndef SYNTHESIS
    // a scan step only ever takes a frame that was free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_step && !cur_busy) |=> (busy_reg[$past(idx)] && map_reg[$past(idx)]))
        else $error("pfa_datapath: scanned frame not marked busy");

    // a check starts the grant from nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.check |=> ((got_reg == '0) && (map_reg == '0)))
        else $error("pfa_datapath: grant not cleared by check");

    // a scan step stays below the active frame count
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> in_range)
        else $error("pfa_datapath: scan stepped past the frame count");
`endif

endmodule

[sv/page_frame_allocator_top.sv]
// ----------------------------------------------------------------------------
// page_frame_allocator_top
// first-fit page frame allocator: one request word in, one grant word out
// ----------------------------------------------------------------------------
// order: accept, check, then the scan for a grant or straight to the result for a
// refused request; the scan walks the busy bitmap one frame per cycle from frame 0
// and stops at the active frame count or once enough are granted
// throughput: one request at a time; the next is accepted only once the last result
// is loaded, which waits while an earlier result still holds the output register
// reset: synchronous, active low; all frames free, none in use, total_frames 64
// ----------------------------------------------------------------------------
module page_frame_allocator_top #(
    parameter int NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF   // built frame count, 1..64
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pfa_pkg::S_TDATA_W-1:0]   s_tdata,    // [15:0] request_bytes

    // grant stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pfa_pkg::M_TDATA_W-1:0]   m_tdata,    // [63:0] granted_map,
                                                        // [70:64] granted_count,
                                                        // [78:71] fragmentation,
                                                        // [79] zero
    output logic [pfa_pkg::STATUS_W-1:0]    m_tuser,    // [1:0] status

    // total_frames register write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pfa_pkg::CFG_W-1:0]       cfg_data
);

    pfa_pkg::pfa_cmd_t              cmd;
    pfa_pkg::pfa_sts_t              sts;
    logic [pfa_pkg::STATUS_W-1:0]   out_status;
    logic [pfa_pkg::MAP_W-1:0]      out_map;
    logic [pfa_pkg::COUNT_W-1:0]    out_count;
    logic [pfa_pkg::FRAG_W-1:0]     out_frag;

    // register writes are always taken; the user must send them only while the block is idle, unenforced
    assign cfg_ready = 1'b1;

    // sequencer: accept, check, scan, hand the result to the output register
    pfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // bitmap, counters, request check and result register
    pfa_datapath #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_in     (s_tdata[pfa_pkg::REQ_W-1:0]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .sts        (sts),
        .out_status (out_status),
        .out_map    (out_map),
        .out_count  (out_count),
        .out_frag   (out_frag)
    );

    // pack the grant word, first field in the lowest bits
    assign m_tdata = {1'b0, out_frag, out_count, out_map};
    assign m_tuser = out_status;

endmodule
